FILE: src/mfic_pkg.sv
// Package: shared constants, state encoding, face and result types and min/max helpers of the face index compactor.
`timescale 1ns / 1ps

package mfic_pkg;

    localparam int DEF_MAX_VERTICES      = 4096;
    localparam int DEF_MAX_TEXCOORDS_IN  = 4096;
    localparam int DEF_MAX_TEXCOORDS_OUT = 8192;

    localparam int VERT_CAP  = 4096;
    localparam int TEX_CAP   = 8192;
    localparam int SRC_IDX_W = 12;
    localparam int VTX_OUT_W = 12;
    localparam int TEX_OUT_W = 13;
    localparam int CORNERS   = 3;
    localparam int EPOCH_W   = 4;

    localparam logic [1:0] LAST_CORNER = 2'd2;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_PREP,
        ST_V_RD,
        ST_V_EV,
        ST_T_RD,
        ST_H_EV,
        ST_C_EV,
        ST_C_LINK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic                                start;
        logic [CORNERS-1:0][SRC_IDX_W-1:0]   vtx;
        logic [CORNERS-1:0][SRC_IDX_W-1:0]   tex;
    } t_face;

    typedef struct packed {
        logic [CORNERS-1:0][VTX_OUT_W-1:0]   vtx;
        logic [CORNERS-1:0][TEX_OUT_W-1:0]   tex;
        logic [CORNERS-1:0]                  vmask;
        logic [CORNERS-1:0]                  tmask;
        logic                                ovf;
    } t_result;

    function automatic int min_int(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    function automatic int max_int(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

FILE: src/mfic_ram.sv
// Single-port-write, single-port-read synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module mfic_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: src/mfic_seq.sv
// Face sequencer: per-corner read-modify-write of the source map and clone-chain walk.
`timescale 1ns / 1ps

module mfic_seq #(
    parameter int MAX_VERTICES      = mfic_pkg::DEF_MAX_VERTICES,
    parameter int MAX_TEXCOORDS_IN  = mfic_pkg::DEF_MAX_TEXCOORDS_IN,
    parameter int MAX_TEXCOORDS_OUT = mfic_pkg::DEF_MAX_TEXCOORDS_OUT,
    localparam int VERT_LIMIT = mfic_pkg::min_int(MAX_VERTICES, mfic_pkg::VERT_CAP),
    localparam int TEX_LIMIT  = mfic_pkg::min_int(MAX_TEXCOORDS_OUT, mfic_pkg::TEX_CAP),
    localparam int SRC_DEPTH  = mfic_pkg::max_int(VERT_LIMIT,
                                    mfic_pkg::min_int(MAX_TEXCOORDS_IN, mfic_pkg::VERT_CAP)),
    localparam int VOUT_W = $clog2(VERT_LIMIT),
    localparam int CH_AW  = $clog2(TEX_LIMIT),
    localparam int SRC_AW = $clog2(SRC_DEPTH),
    localparam int SRC_W  = mfic_pkg::EPOCH_W + 2 + VOUT_W + CH_AW,
    localparam int CH_W   = VOUT_W + CH_AW
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tex_en,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mfic_pkg::t_face     i_face,
    input  logic                i_res_free,
    output logic                o_res_valid,
    output mfic_pkg::t_result   o_result,
    output logic                o_src_rd_en,
    output logic [SRC_AW-1:0]   o_src_rd_addr,
    output logic                o_src_wr_en,
    output logic [SRC_AW-1:0]   o_src_wr_addr,
    output logic [SRC_W-1:0]    o_src_wr_data,
    input  logic [SRC_W-1:0]    i_src_rd_data,
    output logic                o_ch_rd_en,
    output logic [CH_AW-1:0]    o_ch_rd_addr,
    output logic                o_ch_wr_en,
    output logic [CH_AW-1:0]    o_ch_wr_addr,
    output logic [CH_W-1:0]     o_ch_wr_data,
    input  logic [CH_W-1:0]     i_ch_rd_data
);

    localparam int VC_W = $clog2(VERT_LIMIT + 1);
    localparam int TC_W = $clog2(TEX_LIMIT + 1);
    localparam int EP_W = mfic_pkg::EPOCH_W;
    localparam int NC   = mfic_pkg::CORNERS;
    localparam int IW   = mfic_pkg::SRC_IDX_W;

    mfic_pkg::t_state r_state, n_state;
    logic                       r_face, n_face;
    logic [EP_W-1:0]            r_epoch, n_epoch;
    logic [SRC_AW-1:0]          r_sweep, n_sweep;
    logic [1:0]                 r_k, n_k;
    logic [VC_W-1:0]            r_vcount, n_vcount;
    logic [TC_W-1:0]            r_tcount, n_tcount;

    logic [NC-1:0][IW-1:0]      r_v, n_v;
    logic [NC-1:0][IW-1:0]      r_t, n_t;
    logic [NC-1:0][VOUT_W-1:0]  r_rv, n_rv;
    logic [NC-1:0][CH_AW-1:0]   r_rt, n_rt;
    logic [NC-1:0]              r_ok, n_ok;
    logic [NC-1:0]              r_vmask, n_vmask;
    logic [NC-1:0]              r_tmask, n_tmask;
    logic                       r_ovf, n_ovf;
    logic [CH_AW-1:0]           r_idx, n_idx;
    logic [VOUT_W-1:0]          r_cur_vtx, n_cur_vtx;

    logic [EP_W-1:0]    s_ep;
    logic               s_vval, s_hval;
    logic [VOUT_W-1:0]  s_vidx;
    logic [CH_AW-1:0]   s_hidx;
    logic [VOUT_W-1:0]  c_vtx;
    logic [CH_AW-1:0]   c_next;
    logic               degen;

    assign s_ep   = i_src_rd_data[SRC_W-1 -: EP_W];
    assign s_vval = (s_ep == r_epoch) & i_src_rd_data[VOUT_W+CH_AW+1];
    assign s_vidx = i_src_rd_data[CH_AW+1 +: VOUT_W];
    assign s_hval = (s_ep == r_epoch) & i_src_rd_data[CH_AW];
    assign s_hidx = i_src_rd_data[CH_AW-1:0];
    assign c_vtx  = i_ch_rd_data[CH_W-1 -: VOUT_W];
    assign c_next = i_ch_rd_data[CH_AW-1:0];
    assign degen  = (r_v[0] == r_v[1]) || (r_v[1] == r_v[2]) || (r_v[2] == r_v[0]);

    always_comb begin
        logic v_adv;
        logic t_adv;
        logic [EP_W-1:0] ep_inc;

        n_state   = r_state;
        n_face    = r_face;
        n_epoch   = r_epoch;
        n_sweep   = r_sweep;
        n_k       = r_k;
        n_vcount  = r_vcount;
        n_tcount  = r_tcount;
        n_v       = r_v;
        n_t       = r_t;
        n_rv      = r_rv;
        n_rt      = r_rt;
        n_ok      = r_ok;
        n_vmask   = r_vmask;
        n_tmask   = r_tmask;
        n_ovf     = r_ovf;
        n_idx     = r_idx;
        n_cur_vtx = r_cur_vtx;
        v_adv     = 1'b0;
        t_adv     = 1'b0;
        ep_inc    = r_epoch + 1'b1;

        o_in_ready    = 1'b0;
        o_res_valid   = 1'b0;
        o_src_rd_en   = 1'b0;
        o_src_rd_addr = '0;
        o_src_wr_en   = 1'b0;
        o_src_wr_addr = '0;
        o_src_wr_data = '0;
        o_ch_rd_en    = 1'b0;
        o_ch_rd_addr  = '0;
        o_ch_wr_en    = 1'b0;
        o_ch_wr_addr  = '0;
        o_ch_wr_data  = '0;

        case (r_state)
            mfic_pkg::ST_CLEAR: begin
                o_src_wr_en   = 1'b1;
                o_src_wr_addr = r_sweep;
                n_sweep       = r_sweep + 1'b1;
                if (r_sweep == SRC_AW'(SRC_DEPTH - 1)) begin
                    n_sweep = '0;
                    n_state = r_face ? mfic_pkg::ST_PREP : mfic_pkg::ST_IDLE;
                end
            end
            mfic_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_face  = 1'b1;
                    n_v     = i_face.vtx;
                    n_t     = i_face.tex;
                    n_state = mfic_pkg::ST_PREP;
                    if (i_face.start) begin
                        n_vcount = '0;
                        n_tcount = '0;
                        n_epoch  = ep_inc;
                        if (ep_inc == '0) begin
                            n_state = mfic_pkg::ST_CLEAR;
                        end
                    end
                end
            end
            mfic_pkg::ST_PREP: begin
                n_k     = '0;
                n_rv    = '0;
                n_rt    = '0;
                n_ok    = '0;
                n_vmask = '0;
                n_tmask = '0;
                n_ovf   = 1'b0;
                if (degen) begin
                    n_face  = 1'b0;
                    n_state = mfic_pkg::ST_IDLE;
                end else begin
                    n_state = mfic_pkg::ST_V_RD;
                end
            end
            mfic_pkg::ST_V_RD: begin
                if (32'(r_v[r_k]) >= 32'(MAX_VERTICES)) begin
                    n_ovf = 1'b1;
                    v_adv = 1'b1;
                end else begin
                    o_src_rd_en   = 1'b1;
                    o_src_rd_addr = r_v[r_k][SRC_AW-1:0];
                    n_state       = mfic_pkg::ST_V_EV;
                end
            end
            mfic_pkg::ST_V_EV: begin
                v_adv = 1'b1;
                if (s_vval) begin
                    n_rv[r_k] = s_vidx;
                    n_ok[r_k] = 1'b1;
                end else if (r_vcount < VC_W'(VERT_LIMIT)) begin
                    o_src_wr_en    = 1'b1;
                    o_src_wr_addr  = r_v[r_k][SRC_AW-1:0];
                    o_src_wr_data  = {r_epoch, 1'b1, VOUT_W'(r_vcount), s_hval, s_hidx};
                    n_rv[r_k]      = VOUT_W'(r_vcount);
                    n_ok[r_k]      = 1'b1;
                    n_vmask[r_k]   = 1'b1;
                    n_vcount       = r_vcount + 1'b1;
                end else begin
                    n_ovf = 1'b1;
                end
            end
            mfic_pkg::ST_T_RD: begin
                if (!r_ok[r_k]) begin
                    t_adv = 1'b1;
                end else if (32'(r_t[r_k]) >= 32'(MAX_TEXCOORDS_IN)) begin
                    n_ovf = 1'b1;
                    t_adv = 1'b1;
                end else begin
                    o_src_rd_en   = 1'b1;
                    o_src_rd_addr = r_t[r_k][SRC_AW-1:0];
                    n_state       = mfic_pkg::ST_H_EV;
                end
            end
            mfic_pkg::ST_H_EV: begin
                if (s_hval) begin
                    o_ch_rd_en   = 1'b1;
                    o_ch_rd_addr = s_hidx;
                    n_idx        = s_hidx;
                    n_state      = mfic_pkg::ST_C_EV;
                end else if (r_tcount < TC_W'(TEX_LIMIT)) begin
                    t_adv         = 1'b1;
                    o_ch_wr_en    = 1'b1;
                    o_ch_wr_addr  = CH_AW'(r_tcount);
                    o_ch_wr_data  = {r_rv[r_k], {CH_AW{1'b0}}};
                    o_src_wr_en   = 1'b1;
                    o_src_wr_addr = r_t[r_k][SRC_AW-1:0];
                    o_src_wr_data = {r_epoch, s_vval, s_vidx, 1'b1, CH_AW'(r_tcount)};
                    n_rt[r_k]     = CH_AW'(r_tcount);
                    n_tmask[r_k]  = 1'b1;
                    n_tcount      = r_tcount + 1'b1;
                end else begin
                    t_adv = 1'b1;
                    n_ovf = 1'b1;
                end
            end
            mfic_pkg::ST_C_EV: begin
                if (c_vtx == r_rv[r_k]) begin
                    n_rt[r_k] = r_idx;
                    t_adv     = 1'b1;
                end else if (c_next != '0) begin
                    o_ch_rd_en   = 1'b1;
                    o_ch_rd_addr = c_next;
                    n_idx        = c_next;
                end else if (r_tcount < TC_W'(TEX_LIMIT)) begin
                    o_ch_wr_en   = 1'b1;
                    o_ch_wr_addr = CH_AW'(r_tcount);
                    o_ch_wr_data = {r_rv[r_k], {CH_AW{1'b0}}};
                    n_cur_vtx    = c_vtx;
                    n_rt[r_k]    = CH_AW'(r_tcount);
                    n_tmask[r_k] = 1'b1;
                    n_tcount     = r_tcount + 1'b1;
                    n_state      = mfic_pkg::ST_C_LINK;
                end else begin
                    n_ovf = 1'b1;
                    t_adv = 1'b1;
                end
            end
            mfic_pkg::ST_C_LINK: begin
                // append: tail entry now points at the fresh clone
                o_ch_wr_en   = 1'b1;
                o_ch_wr_addr = r_idx;
                o_ch_wr_data = {r_cur_vtx, r_rt[r_k]};
                t_adv        = 1'b1;
            end
            mfic_pkg::ST_DONE: begin
                if (i_res_free) begin
                    o_res_valid = 1'b1;
                    n_face      = 1'b0;
                    n_state     = mfic_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mfic_pkg::ST_IDLE;
            end
        endcase

        if (v_adv) begin
            if (r_k == mfic_pkg::LAST_CORNER) begin
                n_k     = '0;
                n_state = i_tex_en ? mfic_pkg::ST_T_RD : mfic_pkg::ST_DONE;
            end else begin
                n_k     = r_k + 1'b1;
                n_state = mfic_pkg::ST_V_RD;
            end
        end
        if (t_adv) begin
            if (r_k == mfic_pkg::LAST_CORNER) begin
                n_state = mfic_pkg::ST_DONE;
            end else begin
                n_k     = r_k + 1'b1;
                n_state = mfic_pkg::ST_T_RD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= mfic_pkg::ST_CLEAR;
            r_face   <= 1'b0;
            r_epoch  <= '0;
            r_sweep  <= '0;
            r_k      <= '0;
            r_vcount <= '0;
            r_tcount <= '0;
        end else begin
            r_state  <= n_state;
            r_face   <= n_face;
            r_epoch  <= n_epoch;
            r_sweep  <= n_sweep;
            r_k      <= n_k;
            r_vcount <= n_vcount;
            r_tcount <= n_tcount;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v       <= n_v;
        r_t       <= n_t;
        r_rv      <= n_rv;
        r_rt      <= n_rt;
        r_ok      <= n_ok;
        r_vmask   <= n_vmask;
        r_tmask   <= n_tmask;
        r_ovf     <= n_ovf;
        r_idx     <= n_idx;
        r_cur_vtx <= n_cur_vtx;
    end

    always_comb begin
        for (int i = 0; i < NC; i++) begin
            o_result.vtx[i] = mfic_pkg::VTX_OUT_W'(r_rv[i]);
            o_result.tex[i] = mfic_pkg::TEX_OUT_W'(r_rt[i]);
        end
        o_result.vmask = r_vmask;
        o_result.tmask = r_tmask;
        o_result.ovf   = r_ovf;
    end

endmodule

FILE: src/mesh_face_index_compactor.sv
// Top level: face index compactor with config register, result register and table RAMs.
//
// Input channel (i_in_valid / o_in_ready) takes one triangle per transfer: start flag,
// three source vertex indices, three source texture indices. Output channel
// (o_out_valid / i_out_ready) returns one transfer per non-degenerate face; a face with
// a repeated vertex returns nothing. The config channel writes texturing_enabled and is
// always ready; write it only while the block is idle.
// With texturing on, each mapped corner with an in-range texture index also reads the
// source map for that index; a known index walks the clone chain one entry at a time and
// appends a clone when no entry matches. Every in-range corner index is a source-map read
// followed by a write-back when a new slot is allocated; the chain walk is one chain RAM
// read per entry. A degenerate face frees the input without any table access. A new face
// is taken only once the last one is finished, and the next face is taken while a result
// waits in the output register. Reset (synchronous, active low) runs a clearing pass over
// all SRC_DEPTH source map entries (4096 by default) before the first face is accepted;
// the same pass runs on every 16th start_mesh, when the map epoch wraps. A stalled
// receiver holds the result register; the sequencer then waits at the end of the next
// face.
`timescale 1ns / 1ps

module mesh_face_index_compactor #(
    parameter int MAX_VERTICES      = mfic_pkg::DEF_MAX_VERTICES,
    parameter int MAX_TEXCOORDS_IN  = mfic_pkg::DEF_MAX_TEXCOORDS_IN,
    parameter int MAX_TEXCOORDS_OUT = mfic_pkg::DEF_MAX_TEXCOORDS_OUT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_texturing_enabled,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_start_mesh,
    input  logic [11:0] i_vertex_a,
    input  logic [11:0] i_vertex_b,
    input  logic [11:0] i_vertex_c,
    input  logic [11:0] i_texcoord_a,
    input  logic [11:0] i_texcoord_b,
    input  logic [11:0] i_texcoord_c,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [11:0] o_out_vertex_a,
    output logic [11:0] o_out_vertex_b,
    output logic [11:0] o_out_vertex_c,
    output logic [12:0] o_out_texcoord_a,
    output logic [12:0] o_out_texcoord_b,
    output logic [12:0] o_out_texcoord_c,
    output logic [2:0]  o_new_vertex_mask,
    output logic [2:0]  o_new_texcoord_mask,
    output logic        o_overflow
);

    localparam int VERT_LIMIT = mfic_pkg::min_int(MAX_VERTICES, mfic_pkg::VERT_CAP);
    localparam int TEX_LIMIT  = mfic_pkg::min_int(MAX_TEXCOORDS_OUT, mfic_pkg::TEX_CAP);
    localparam int SRC_DEPTH  = mfic_pkg::max_int(VERT_LIMIT,
                                    mfic_pkg::min_int(MAX_TEXCOORDS_IN, mfic_pkg::VERT_CAP));
    localparam int VOUT_W = $clog2(VERT_LIMIT);
    localparam int CH_AW  = $clog2(TEX_LIMIT);
    localparam int SRC_AW = $clog2(SRC_DEPTH);
    localparam int SRC_W  = mfic_pkg::EPOCH_W + 2 + VOUT_W + CH_AW;
    localparam int CH_W   = VOUT_W + CH_AW;

    logic               r_tex_en;
    logic               r_out_valid;
    mfic_pkg::t_result  r_out;
    mfic_pkg::t_result  seq_result;
    mfic_pkg::t_face    face;
    logic               res_free;
    logic               res_valid;

    logic               src_rd_en, src_wr_en;
    logic [SRC_AW-1:0]  src_rd_addr, src_wr_addr;
    logic [SRC_W-1:0]   src_wr_data, src_rd_data;
    logic               ch_rd_en, ch_wr_en;
    logic [CH_AW-1:0]   ch_rd_addr, ch_wr_addr;
    logic [CH_W-1:0]    ch_wr_data, ch_rd_data;

    assign o_cfg_ready = 1'b1;
    assign res_free    = !r_out_valid || i_out_ready;

    assign face.start  = i_start_mesh;
    assign face.vtx[0] = i_vertex_a;
    assign face.vtx[1] = i_vertex_b;
    assign face.vtx[2] = i_vertex_c;
    assign face.tex[0] = i_texcoord_a;
    assign face.tex[1] = i_texcoord_b;
    assign face.tex[2] = i_texcoord_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tex_en    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tex_en <= i_cfg_texturing_enabled;
            end
            if (res_valid) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= seq_result;
        end
    end

    mfic_seq #(
        .MAX_VERTICES      (MAX_VERTICES),
        .MAX_TEXCOORDS_IN  (MAX_TEXCOORDS_IN),
        .MAX_TEXCOORDS_OUT (MAX_TEXCOORDS_OUT)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tex_en      (r_tex_en),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_face        (face),
        .i_res_free    (res_free),
        .o_res_valid   (res_valid),
        .o_result      (seq_result),
        .o_src_rd_en   (src_rd_en),
        .o_src_rd_addr (src_rd_addr),
        .o_src_wr_en   (src_wr_en),
        .o_src_wr_addr (src_wr_addr),
        .o_src_wr_data (src_wr_data),
        .i_src_rd_data (src_rd_data),
        .o_ch_rd_en    (ch_rd_en),
        .o_ch_rd_addr  (ch_rd_addr),
        .o_ch_wr_en    (ch_wr_en),
        .o_ch_wr_addr  (ch_wr_addr),
        .o_ch_wr_data  (ch_wr_data),
        .i_ch_rd_data  (ch_rd_data)
    );

    mfic_ram #(
        .DEPTH (SRC_DEPTH),
        .WIDTH (SRC_W)
    ) u_src_map (
        .i_clk     (i_clk),
        .i_wr_en   (src_wr_en),
        .i_wr_addr (src_wr_addr),
        .i_wr_data (src_wr_data),
        .i_rd_en   (src_rd_en),
        .i_rd_addr (src_rd_addr),
        .o_rd_data (src_rd_data)
    );

    mfic_ram #(
        .DEPTH (TEX_LIMIT),
        .WIDTH (CH_W)
    ) u_chain (
        .i_clk     (i_clk),
        .i_wr_en   (ch_wr_en),
        .i_wr_addr (ch_wr_addr),
        .i_wr_data (ch_wr_data),
        .i_rd_en   (ch_rd_en),
        .i_rd_addr (ch_rd_addr),
        .o_rd_data (ch_rd_data)
    );

    assign o_out_valid         = r_out_valid;
    assign o_out_vertex_a      = r_out.vtx[0];
    assign o_out_vertex_b      = r_out.vtx[1];
    assign o_out_vertex_c      = r_out.vtx[2];
    assign o_out_texcoord_a    = r_out.tex[0];
    assign o_out_texcoord_b    = r_out.tex[1];
    assign o_out_texcoord_c    = r_out.tex[2];
    assign o_new_vertex_mask   = r_out.vmask;
    assign o_new_texcoord_mask = r_out.tmask;
    assign o_overflow          = r_out.ovf;

endmodule

FILE: test/tb_mesh_face_index_compactor.sv
// Testbench: directed and randomized face traffic against a behavioral predictor of the face index compactor.
`timescale 1ns / 1ps

module tb_mesh_face_index_compactor;

    localparam int DEF_MAX_VERTICES      = mfic_pkg::DEF_MAX_VERTICES;
    localparam int DEF_MAX_TEXCOORDS_IN  = mfic_pkg::DEF_MAX_TEXCOORDS_IN;
    localparam int DEF_MAX_TEXCOORDS_OUT = mfic_pkg::DEF_MAX_TEXCOORDS_OUT;
    localparam int VERT_CAP  = mfic_pkg::VERT_CAP;
    localparam int TEX_CAP   = mfic_pkg::TEX_CAP;
    localparam int SRC_IDX_W = mfic_pkg::SRC_IDX_W;
    localparam int VTX_OUT_W = mfic_pkg::VTX_OUT_W;
    localparam int TEX_OUT_W = mfic_pkg::TEX_OUT_W;
    localparam int CORNERS   = mfic_pkg::CORNERS;

    localparam int MAX_VERTS     = DEF_MAX_VERTICES;
    localparam int MAX_TC_IN     = DEF_MAX_TEXCOORDS_IN;
    localparam int MAX_TC_OUT    = DEF_MAX_TEXCOORDS_OUT;
    localparam int VERT_LIMIT    = (MAX_VERTS < VERT_CAP) ? MAX_VERTS : VERT_CAP;
    localparam int TC_LIMIT      = (MAX_TC_OUT < TEX_CAP) ? MAX_TC_OUT : TEX_CAP;
    localparam int SETTLE_CYCLES = 300;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int MAX_PRINTED   = 100;

    typedef struct packed {
        bit                                start;
        bit [CORNERS-1:0][SRC_IDX_W-1:0]   vtx;
        bit [CORNERS-1:0][SRC_IDX_W-1:0]   tex;
    } t_face_item;

    typedef struct packed {
        bit [CORNERS-1:0][VTX_OUT_W-1:0]   vtx;
        bit [CORNERS-1:0][TEX_OUT_W-1:0]   tex;
        bit [CORNERS-1:0]                  vmask;
        bit [CORNERS-1:0]                  tmask;
        bit                                ovf;
    } t_remap_item;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_texturing_enabled = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_start_mesh = 1'b0;
    logic [11:0] i_vertex_a = '0;
    logic [11:0] i_vertex_b = '0;
    logic [11:0] i_vertex_c = '0;
    logic [11:0] i_texcoord_a = '0;
    logic [11:0] i_texcoord_b = '0;
    logic [11:0] i_texcoord_c = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [11:0] o_out_vertex_a;
    logic [11:0] o_out_vertex_b;
    logic [11:0] o_out_vertex_c;
    logic [12:0] o_out_texcoord_a;
    logic [12:0] o_out_texcoord_b;
    logic [12:0] o_out_texcoord_c;
    logic [2:0]  o_new_vertex_mask;
    logic [2:0]  o_new_texcoord_mask;
    logic        o_overflow;

    mesh_face_index_compactor i_dut (
        .i_clk                   (i_clk),
        .i_rst_n                 (i_rst_n),
        .i_cfg_valid             (i_cfg_valid),
        .o_cfg_ready             (o_cfg_ready),
        .i_cfg_texturing_enabled (i_cfg_texturing_enabled),
        .i_in_valid              (i_in_valid),
        .o_in_ready              (o_in_ready),
        .i_start_mesh            (i_start_mesh),
        .i_vertex_a              (i_vertex_a),
        .i_vertex_b              (i_vertex_b),
        .i_vertex_c              (i_vertex_c),
        .i_texcoord_a            (i_texcoord_a),
        .i_texcoord_b            (i_texcoord_b),
        .i_texcoord_c            (i_texcoord_c),
        .o_out_valid             (o_out_valid),
        .i_out_ready             (i_out_ready),
        .o_out_vertex_a          (o_out_vertex_a),
        .o_out_vertex_b          (o_out_vertex_b),
        .o_out_vertex_c          (o_out_vertex_c),
        .o_out_texcoord_a        (o_out_texcoord_a),
        .o_out_texcoord_b        (o_out_texcoord_b),
        .o_out_texcoord_c        (o_out_texcoord_c),
        .o_new_vertex_mask       (o_new_vertex_mask),
        .o_new_texcoord_mask     (o_new_texcoord_mask),
        .o_overflow              (o_overflow)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    bit                 texturing_on;
    bit                 vmap_used [MAX_VERTS];
    bit [VTX_OUT_W-1:0] vmap_slot [MAX_VERTS];
    int unsigned        vertex_total;
    bit                 head_used [MAX_TC_IN];
    bit [TEX_OUT_W-1:0] head_slot [MAX_TC_IN];
    bit [VTX_OUT_W-1:0] link_owner [MAX_TC_OUT];
    bit [TEX_OUT_W-1:0] link_next [MAX_TC_OUT];
    int unsigned        texcoord_total;

    t_face_item  face_q [$];
    t_remap_item remap_q [$];
    int          mismatch_count;
    int          result_no;
    int          cycle_count;

    function automatic void clear_tables();
        int k;
        for (k = 0; k < MAX_VERTS; k++) begin
            vmap_used[k] = 1'b0;
            vmap_slot[k] = '0;
        end
        for (k = 0; k < MAX_TC_IN; k++) begin
            head_used[k] = 1'b0;
            head_slot[k] = '0;
        end
        for (k = 0; k < MAX_TC_OUT; k++) begin
            link_owner[k] = '0;
            link_next[k]  = '0;
        end
        vertex_total   = 0;
        texcoord_total = 0;
    endfunction

    function automatic bit is_degenerate(input t_face_item f);
        return (f.vtx[0] == f.vtx[1]) || (f.vtx[1] == f.vtx[2]) || (f.vtx[2] == f.vtx[0]);
    endfunction

    function automatic bit alloc_texcoord(input bit [VTX_OUT_W-1:0] owner,
                                          output bit [TEX_OUT_W-1:0] slot);
        slot = '0;
        if (texcoord_total >= TC_LIMIT)
            return 1'b0;
        slot = texcoord_total[TEX_OUT_W-1:0];
        link_owner[slot] = owner;
        link_next[slot]  = '0;
        texcoord_total++;
        return 1'b1;
    endfunction

    // -1: no entry available, 0: existing entry, 1: new entry
    function automatic int map_texcoord(input bit [SRC_IDX_W-1:0] src,
                                        input bit [VTX_OUT_W-1:0] owner,
                                        output bit [TEX_OUT_W-1:0] slot);
        int unsigned        idx;
        int unsigned        steps;
        bit [TEX_OUT_W-1:0] fresh;
        slot = '0;
        if (src >= MAX_TC_IN)
            return -1;
        if (!head_used[src]) begin
            if (!alloc_texcoord(owner, fresh))
                return -1;
            head_used[src] = 1'b1;
            head_slot[src] = fresh;
            slot = fresh;
            return 1;
        end
        idx = 32'(head_slot[src]);
        for (steps = 0; steps <= texcoord_total; steps++) begin
            if (idx >= MAX_TC_OUT)
                return -1;
            if (link_owner[idx] == owner) begin
                slot = idx[TEX_OUT_W-1:0];
                return 0;
            end
            if (link_next[idx] == 0) begin
                if (!alloc_texcoord(owner, fresh))
                    return -1;
                link_next[idx] = fresh;
                slot = fresh;
                return 1;
            end
            idx = 32'(link_next[idx]);
        end
        return -1;
    endfunction

    function automatic bit predict_face(input t_face_item f, output t_remap_item r);
        bit [CORNERS-1:0]   mapped;
        bit [TEX_OUT_W-1:0] slot;
        int                 i;
        int                 st;
        r = '0;
        mapped = '0;
        if (f.start)
            clear_tables();
        if (is_degenerate(f))
            return 1'b0;
        for (i = 0; i < CORNERS; i++) begin
            if (f.vtx[i] >= MAX_VERTS) begin
                r.ovf = 1'b1;
            end else if (vmap_used[f.vtx[i]]) begin
                r.vtx[i] = vmap_slot[f.vtx[i]];
                mapped[i] = 1'b1;
            end else if (vertex_total < VERT_LIMIT) begin
                r.vtx[i] = vertex_total[VTX_OUT_W-1:0];
                vmap_used[f.vtx[i]] = 1'b1;
                vmap_slot[f.vtx[i]] = vertex_total[VTX_OUT_W-1:0];
                vertex_total++;
                r.vmask[i] = 1'b1;
                mapped[i] = 1'b1;
            end else begin
                r.ovf = 1'b1;
            end
        end
        if (texturing_on) begin
            for (i = 0; i < CORNERS; i++) begin
                if (mapped[i]) begin
                    st = map_texcoord(f.tex[i], r.vtx[i], slot);
                    if (st < 0) begin
                        r.tex[i] = '0;
                        r.ovf = 1'b1;
                    end else begin
                        r.tex[i] = slot;
                        if (st > 0)
                            r.tmask[i] = 1'b1;
                    end
                end
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_remap(input t_remap_item got);
        t_remap_item want;
        int          i;
        if (remap_q.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no face pending", result_no));
        end else begin
            want = remap_q.pop_front();
            for (i = 0; i < CORNERS; i++) begin
                if (got.vtx[i] != want.vtx[i])
                    report_mismatch($sformatf("result %0d corner %0d vertex got %0d want %0d",
                                              result_no, i, got.vtx[i], want.vtx[i]));
                if (got.tex[i] != want.tex[i])
                    report_mismatch($sformatf("result %0d corner %0d texcoord got %0d want %0d",
                                              result_no, i, got.tex[i], want.tex[i]));
            end
            if (got.vmask != want.vmask)
                report_mismatch($sformatf("result %0d vertex mask got %b want %b",
                                          result_no, got.vmask, want.vmask));
            if (got.tmask != want.tmask)
                report_mismatch($sformatf("result %0d texcoord mask got %b want %b",
                                          result_no, got.tmask, want.tmask));
            if (got.ovf != want.ovf)
                report_mismatch($sformatf("result %0d overflow got %0d want %0d",
                                          result_no, got.ovf, want.ovf));
        end
        result_no++;
    endtask

    // Face driver
    t_face_item  cur_face;
    t_remap_item pending_remap;
    bit          face_held;
    bit          send_burst;
    int          send_gap;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            send_gap = $urandom_range(0, 7);
        end else begin
            face_held = i_in_valid;
            if (i_in_valid && o_in_ready) begin
                if (predict_face(cur_face, pending_remap))
                    remap_q = {remap_q, pending_remap};
                face_held = 1'b0;
                send_gap = send_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 63) == 0)
                    send_burst = !send_burst;
            end
            if (!face_held) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (face_q.size() != 0) begin
                    cur_face = face_q.pop_front();
                    i_start_mesh <= cur_face.start;
                    i_vertex_a   <= cur_face.vtx[0];
                    i_vertex_b   <= cur_face.vtx[1];
                    i_vertex_c   <= cur_face.vtx[2];
                    i_texcoord_a <= cur_face.tex[0];
                    i_texcoord_b <= cur_face.tex[1];
                    i_texcoord_c <= cur_face.tex[2];
                    face_held = 1'b1;
                end
            end
            i_in_valid <= face_held;
        end
    end

    // Result monitor
    t_remap_item seen_remap;
    bit          recv_burst;
    int          recv_hold;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            recv_hold = 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                seen_remap.vtx   = {o_out_vertex_c, o_out_vertex_b, o_out_vertex_a};
                seen_remap.tex   = {o_out_texcoord_c, o_out_texcoord_b, o_out_texcoord_a};
                seen_remap.vmask = o_new_vertex_mask;
                seen_remap.tmask = o_new_texcoord_mask;
                seen_remap.ovf   = o_overflow;
                check_remap(seen_remap);
                recv_hold = recv_burst ? 0 : $urandom_range(0, 7);
                if ($urandom_range(0, 63) == 0)
                    recv_burst = !recv_burst;
            end else if (o_out_valid && recv_hold > 0) begin
                recv_hold--;
            end
            i_out_ready <= (recv_hold == 0);
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic queue_face(input bit start, input int va, input int vb, input int vc,
                              input int ta, input int tb, input int tc);
        t_face_item f;
        f.start  = start;
        f.vtx[0] = SRC_IDX_W'(va);
        f.vtx[1] = SRC_IDX_W'(vb);
        f.vtx[2] = SRC_IDX_W'(vc);
        f.tex[0] = SRC_IDX_W'(ta);
        f.tex[1] = SRC_IDX_W'(tb);
        f.tex[2] = SRC_IDX_W'(tc);
        face_q = {face_q, f};
    endtask

    // Short meshes, mostly from small index pools so vertices repeat and texcoords build clone chains.
    task automatic queue_short_meshes(input int n, input bit open_mesh);
        t_face_item         f;
        int                 k;
        int                 c;
        int                 x;
        int                 y;
        bit [SRC_IDX_W-1:0] vbase;
        bit [SRC_IDX_W-1:0] tbase;
        vbase = SRC_IDX_W'($urandom_range(0, 4080));
        tbase = SRC_IDX_W'($urandom_range(0, 4088));
        for (k = 0; k < n; k++) begin
            f = '0;
            f.start = (open_mesh && k == 0) || ($urandom_range(0, 11) == 0);
            if (f.start) begin
                vbase = SRC_IDX_W'($urandom_range(0, 4080));
                tbase = SRC_IDX_W'($urandom_range(0, 4088));
            end
            if ($urandom_range(0, 9) < 7) begin
                do begin
                    for (c = 0; c < CORNERS; c++)
                        f.vtx[c] = vbase + SRC_IDX_W'($urandom_range(0, 15));
                end while (is_degenerate(f));
                for (c = 0; c < CORNERS; c++)
                    f.tex[c] = tbase + SRC_IDX_W'($urandom_range(0, 7));
            end else begin
                do begin
                    for (c = 0; c < CORNERS; c++)
                        f.vtx[c] = SRC_IDX_W'($urandom);
                end while (is_degenerate(f));
                for (c = 0; c < CORNERS; c++)
                    f.tex[c] = SRC_IDX_W'($urandom);
            end
            if ($urandom_range(0, 11) == 0) begin
                x = $urandom_range(0, 2);
                y = (x + 1 + $urandom_range(0, 1)) % CORNERS;
                f.vtx[y] = f.vtx[x];
            end
            face_q = {face_q, f};
        end
    endtask

    // One long mesh of random faces that fills a large part of the texcoord table.
    task automatic queue_long_mesh(input int n);
        t_face_item f;
        int         k;
        int         c;
        for (k = 0; k < n; k++) begin
            f = '0;
            f.start = (k == 0);
            do begin
                for (c = 0; c < CORNERS; c++)
                    f.vtx[c] = SRC_IDX_W'($urandom);
            end while (is_degenerate(f));
            for (c = 0; c < CORNERS; c++)
                f.tex[c] = SRC_IDX_W'($urandom);
            face_q = {face_q, f};
        end
    endtask

    task automatic wait_drained();
        while (!(face_q.size() == 0 && !i_in_valid && remap_q.size() == 0))
            @(negedge i_clk);
    endtask

    task automatic write_texturing(input bit on);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_texturing_enabled <= on;
        do
            @(posedge i_clk);
        while (!(i_cfg_valid && o_cfg_ready));
        i_cfg_valid <= 1'b0;
        texturing_on = on;
    endtask

    initial begin
        texturing_on   = 1'b0;
        mismatch_count = 0;
        result_no      = 0;
        cycle_count    = 0;
        send_burst     = 1'b0;
        recv_burst     = 1'b0;
        clear_tables();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // texturing off from reset
        queue_face(1'b1, 0, 1, 2, 4095, 0, 17);
        queue_face(1'b0, 3, 0, 4095, 1, 2, 3);
        queue_face(1'b0, 4095, 2, 3, 4095, 4095, 4095);

        write_texturing(1'b1);
        queue_face(1'b1, 0, 1, 2, 0, 0, 0);
        queue_face(1'b0, 2, 1, 0, 0, 0, 0);
        queue_face(1'b0, 3, 4, 0, 0, 0, 0);
        queue_face(1'b0, 4095, 4094, 4093, 4095, 4095, 4095);
        queue_face(1'b0, 5, 5, 6, 1, 2, 3);
        queue_face(1'b0, 7, 8, 7, 1, 2, 3);
        queue_face(1'b0, 9, 10, 10, 1, 2, 3);
        queue_face(1'b1, 11, 11, 12, 0, 0, 0);
        queue_face(1'b0, 0, 4095, 2048, 4095, 0, 2048);
        queue_face(1'b0, 4095, 2048, 0, 4095, 0, 2048);
        queue_face(1'b0, 1, 2, 3, 0, 1, 2);
        queue_face(1'b0, 0, 1, 2, 1, 1, 1);
        queue_face(1'b0, 2730, 1365, 3276, 2730, 1365, 819);
        queue_face(1'b1, 4095, 0, 1, 7, 7, 7);
        queue_face(1'b0, 1, 4095, 0, 7, 7, 7);

        queue_short_meshes(250, 1'b1);
        write_texturing(1'b0);
        queue_short_meshes(150, 1'b0);
        write_texturing(1'b1);
        queue_short_meshes(150, 1'b0);
        write_texturing(1'b0);
        queue_short_meshes(60, 1'b0);
        write_texturing(1'b1);
        queue_long_mesh(1270);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (remap_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", remap_q.size()));
        if (mismatch_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/mfic_pkg.sv
src/mfic_ram.sv
src/mfic_seq.sv
src/mesh_face_index_compactor.sv
test/tb_mesh_face_index_compactor.sv
